FILE: rtl/dps_pkg.sv
// Package for the discrete probability table sampler.
// Holds field widths, Q1.32 constants, operation and status codes, controller states
// and the result record passed from the controller to the top level.
package dps_pkg;

	localparam int NUM_KEYS_DEF = 256;
	localparam int KEY_W        = 8;
	localparam int PROB_W       = 33;
	localparam int U_W          = 32;
	localparam int CDF_W        = 34;

	localparam logic [PROB_W-1:0] ONE_Q32 = 33'h1_0000_0000;
	localparam logic [PROB_W-1:0] MAX_Q32 = 33'h1_FFFF_FFFF;

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_CLOSE  = 2'd1,
		OP_SAMPLE = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_DUP  = 2'd1,
		STAT_OVER = 2'd2,
		STAT_MISS = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_LOAD_RD,
		S_CLOSE_RD,
		S_WALK,
		S_DONE
	} state_t;

	typedef struct packed {
		logic             valid;
		status_t          status;
		logic [KEY_W-1:0] sample_key;
	} dps_res_t;

endpackage

FILE: rtl/dps_if.sv
// Handshake channels of the sampler: command items, result items, register writes.
// Depends on dps_pkg for the field widths.
interface dps_cmd_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  opcode;
	logic [dps_pkg::KEY_W-1:0]   entry_key;
	logic [dps_pkg::PROB_W-1:0]  entry_prob;
	logic [dps_pkg::U_W-1:0]     uniform_value;

	modport source (output valid, opcode, entry_key, entry_prob, uniform_value, input ready);
	modport sink   (input valid, opcode, entry_key, entry_prob, uniform_value, output ready);
endinterface

interface dps_rsp_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                status;
	logic [dps_pkg::KEY_W-1:0] sample_key;

	modport source (output valid, status, sample_key, input ready);
	modport sink   (input valid, status, sample_key, output ready);
endinterface

interface dps_cfg_if;
	logic valid;
	logic ready;
	logic deficit_mode;

	modport source (output valid, deficit_mode, input ready);
	modport sink   (input valid, deficit_mode, output ready);
endinterface

FILE: rtl/dps_ram.sv
// Probability table storage: one write port, one read port, registered read data.
// No dependencies.
module dps_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 33,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/dps_ctrl.sv
// Sequencer of the sampler: load, close, sample walk and clearing pass over the table.
// Depends on dps_pkg and dps_cmd_if; drives the ports of dps_ram.
module dps_ctrl #(
	parameter int NUM_KEYS = dps_pkg::NUM_KEYS_DEF,
	parameter int AW       = $clog2(NUM_KEYS)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	dps_cmd_if.sink                    cmd,
	input  logic                       deficit_mode,
	input  logic                       out_free,
	output dps_pkg::dps_res_t          res,
	output logic                       ram_re,
	output logic [AW-1:0]              ram_raddr,
	input  logic [dps_pkg::PROB_W-1:0] ram_rdata,
	output logic                       ram_we,
	output logic [AW-1:0]              ram_waddr,
	output logic [dps_pkg::PROB_W-1:0] ram_wdata
);
	import dps_pkg::*;

	localparam logic [AW-1:0] LAST_IDX = AW'(NUM_KEYS - 1);
	localparam logic [AW-1:0] KEY_ONE  = AW'(1);

	state_t              state_q, state_nxt;
	logic [AW-1:0]       idx_q;
	logic [AW-1:0]       last_q;
	logic [PROB_W-1:0]   sum_q;
	logic                pend_q;
	logic [AW-1:0]       key_q;
	logic [PROB_W-1:0]   prob_q;
	logic [U_W-1:0]      u_q;
	logic [CDF_W-1:0]    cdf_q;
	status_t             res_status_q;
	logic [KEY_W-1:0]    res_key_q;

	op_t                 op_in;
	logic                key_ok;
	logic [AW-1:0]       key_in;
	logic [AW-1:0]       target;
	logic [CDF_W-1:0]    cdf_nxt;
	logic                hit;
	logic [CDF_W-1:0]    load_sum;
	logic [PROB_W-1:0]   load_sum_sat;
	logic [CDF_W-1:0]    fill;
	logic [PROB_W-1:0]   fill_sat;
	logic                dup;

	assign op_in   = op_t'(cmd.opcode);
	assign key_ok  = (32'(cmd.entry_key) < 32'(NUM_KEYS));
	assign key_in  = AW'(cmd.entry_key);
	assign target  = deficit_mode ? KEY_ONE : last_q;

	// Walk step: accumulate the entry read last cycle, stop on the first sum above u.
	assign cdf_nxt = cdf_q + CDF_W'(ram_rdata);
	assign hit     = (cdf_nxt > CDF_W'(u_q));

	assign load_sum     = CDF_W'(sum_q) + CDF_W'(prob_q);
	assign load_sum_sat = (load_sum > CDF_W'(MAX_Q32)) ? MAX_Q32 : load_sum[PROB_W-1:0];
	assign fill         = CDF_W'(ram_rdata) + CDF_W'(ONE_Q32 - sum_q);
	assign fill_sat     = (fill > CDF_W'(MAX_Q32)) ? MAX_Q32 : fill[PROB_W-1:0];
	assign dup          = (ram_rdata != '0);

	assign cmd.ready      = (state_q == S_IDLE);
	assign res.valid      = (state_q == S_DONE);
	assign res.status     = res_status_q;
	assign res.sample_key = res_key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		ram_re    = 1'b0;
		ram_raddr = key_in;
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = '0;
		case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q;
				if (idx_q == LAST_IDX) begin
					state_nxt = pend_q ? S_DONE : S_IDLE;
				end
			end
			S_IDLE: begin
				if (cmd.valid) begin
					case (op_in)
						OP_LOAD: begin
							if (key_ok) begin
								ram_re    = 1'b1;
								ram_raddr = key_in;
								state_nxt = S_LOAD_RD;
							end else begin
								state_nxt = S_DONE;
							end
						end
						OP_CLOSE: begin
							if (sum_q < ONE_Q32) begin
								ram_re    = 1'b1;
								ram_raddr = target;
								state_nxt = S_CLOSE_RD;
							end else begin
								state_nxt = S_DONE;
							end
						end
						OP_SAMPLE: begin
							ram_re    = 1'b1;
							ram_raddr = '0;
							state_nxt = S_WALK;
						end
						OP_CLEAR: begin
							state_nxt = S_CLEAR;
						end
						default: begin
							state_nxt = S_DONE;
						end
					endcase
				end
			end
			S_LOAD_RD: begin
				if (!dup) begin
					ram_we    = 1'b1;
					ram_waddr = key_q;
					ram_wdata = prob_q;
				end
				state_nxt = S_DONE;
			end
			S_CLOSE_RD: begin
				ram_we    = 1'b1;
				ram_waddr = key_q;
				ram_wdata = fill_sat;
				state_nxt = S_DONE;
			end
			S_WALK: begin
				if (hit || (idx_q == LAST_IDX)) begin
					state_nxt = S_DONE;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = idx_q + KEY_ONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_CLEAR;
			end
		endcase
	end

	// Control state: table sum, last loaded key, sweep/walk index, owed clear result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			last_q <= '0;
			sum_q  <= '0;
			pend_q <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					idx_q <= idx_q + KEY_ONE;
				end
				S_IDLE: begin
					if (cmd.valid) begin
						if (op_in == OP_SAMPLE) begin
							idx_q <= '0;
						end else if (op_in == OP_CLEAR) begin
							idx_q  <= '0;
							last_q <= '0;
							sum_q  <= '0;
							pend_q <= 1'b1;
						end
					end
				end
				S_LOAD_RD: begin
					if (!dup) begin
						sum_q  <= load_sum_sat;
						last_q <= key_q;
					end
				end
				S_CLOSE_RD: begin
					sum_q <= ONE_Q32;
				end
				S_WALK: begin
					if (!hit && (idx_q != LAST_IDX)) begin
						idx_q <= idx_q + KEY_ONE;
					end
				end
				S_DONE: begin
					pend_q <= 1'b0;
				end
				default: begin
					pend_q <= 1'b0;
				end
			endcase
		end
	end

	// Item payload and the result being built.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (cmd.valid) begin
					res_status_q <= ((op_in == OP_CLOSE) && (sum_q > ONE_Q32)) ?
						STAT_OVER : STAT_OK;
					res_key_q    <= '0;
					key_q        <= (op_in == OP_CLOSE) ? target : key_in;
					prob_q       <= cmd.entry_prob;
					u_q          <= cmd.uniform_value;
					cdf_q        <= '0;
				end
			end
			S_LOAD_RD: begin
				if (dup) begin
					res_status_q <= STAT_DUP;
				end
			end
			S_WALK: begin
				if (hit) begin
					res_key_q <= KEY_W'(idx_q);
				end else if (idx_q == LAST_IDX) begin
					res_status_q <= STAT_MISS;
				end else begin
					cdf_q <= cdf_nxt;
				end
			end
			default: begin
				cdf_q <= cdf_q;
			end
		endcase
	end

endmodule

FILE: rtl/discrete_pdf_sampler.sv
// Load and close read one table entry and write it; a duplicate load skips the write.
// No entry is touched for a close at or above one or a key past the table. Clear writes
// every entry. A sample returning key k reads entries 0 to k, one table read per key.
// Throughput: one item at a time; the next item is taken once the result sits in the output reg.
// Reset: asynchronous, active low; a clearing pass over every table entry follows reset
// with no command taken, register writes are taken throughout. Depends on dps_pkg, dps_if.
module discrete_pdf_sampler #(
	parameter int NUM_KEYS = dps_pkg::NUM_KEYS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	dps_cmd_if.sink    cmd,
	dps_rsp_if.source  rsp,
	dps_cfg_if.sink    cfg
);
	import dps_pkg::*;

	localparam int AW = $clog2(NUM_KEYS);

	// Deficit mode register; clear commands leave it alone.
	logic              deficit_mode_q;

	// Output register decouples the result from the next command.
	logic              out_valid_q;
	logic [1:0]        out_status_q;
	logic [KEY_W-1:0]  out_key_q;
	logic              out_free;

	dps_res_t          res;

	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [PROB_W-1:0] ram_rdata;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [PROB_W-1:0] ram_wdata;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deficit_mode_q <= 1'b0;
		end else if (cfg.valid) begin
			deficit_mode_q <= cfg.deficit_mode;
		end
	end

	// Slot is free when empty or being drained this cycle.
	assign out_free = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Hold the payload while the sink stalls.
	always_ff @(posedge clk) begin
		if (res.valid && out_free) begin
			out_status_q <= res.status;
			out_key_q    <= res.sample_key;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_status_q;
	assign rsp.sample_key = out_key_q;

	// Probability table, one entry per key.
	dps_ram #(
		.DEPTH (NUM_KEYS),
		.WIDTH (PROB_W),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata)
	);

	// Sequencer: read-modify-write for load and close, key-order walk for sample, clearing pass for clear.
	dps_ctrl #(
		.NUM_KEYS (NUM_KEYS),
		.AW       (AW)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.deficit_mode (deficit_mode_q),
		.out_free     (out_free),
		.res          (res),
		.ram_re       (ram_re),
		.ram_raddr    (ram_raddr),
		.ram_rdata    (ram_rdata),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata)
	);

endmodule

FILE: rtl/dps_checker.sv
// Port-level checks for discrete_pdf_sampler, attached by the bind at the end.
// Depends on dps_pkg for the status codes.
module dps_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      cmd_valid,
	input logic                      cmd_ready,
	input logic                      rsp_valid,
	input logic                      rsp_ready,
	input logic [1:0]                rsp_status,
	input logic [dps_pkg::KEY_W-1:0] rsp_sample_key
);
	import dps_pkg::*;

	logic       cmd_acc;
	logic       rsp_acc;
	logic [1:0] open_q;

	assign cmd_acc = cmd_valid && cmd_ready;
	assign rsp_acc = rsp_valid && rsp_ready;

	// Count items accepted but not yet answered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
		end else begin
			open_q <= open_q + 2'(cmd_acc) - 2'(rsp_acc);
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_sample_key))
		else $error("result changed while stalled");

	a_err_key_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != STAT_OK) |-> rsp_sample_key == '0)
		else $error("error result carries a nonzero key");

	a_no_extra_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_acc |-> open_q != 2'd0)
		else $error("result with no open item");

	a_one_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc |-> open_q <= 2'd1)
		else $error("item taken with more than one result outstanding");

endmodule

bind discrete_pdf_sampler dps_checker u_dps_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.cmd_valid      (cmd.valid),
	.cmd_ready      (cmd.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_status     (rsp.status),
	.rsp_sample_key (rsp.sample_key)
);
